[rtl/core/slcd_pkg.sv]
// Shared types, byte codes and CRC helper for the SLIP/CRC deframer.
`default_nettype none
package slcd_pkg;

    localparam int MAX_PAYLOAD_DEF = 256;
    localparam int MAX_PACKET_DEF  = 261;

    localparam logic [7:0] BYTE_END     = 8'hC0;
    localparam logic [7:0] BYTE_ESC     = 8'hDB;
    localparam logic [7:0] BYTE_ESC_END = 8'hDC;
    localparam logic [7:0] BYTE_ESC_ESC = 8'hDD;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // header is command + two length bytes, trailer is two CRC bytes
    localparam int HDR_BYTES   = 3;
    localparam int FRAME_EXTRA = 5;

    localparam int OUT_DATA_W = 56;

    typedef enum logic [1:0] {
        TOK_DATA,
        TOK_CLOSE,
        TOK_ABORT
    } tok_kind_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_SHORT,
        ST_LEN,
        ST_CRC,
        ST_OVF
    } status_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [7:0] data;
        logic       dovf;
    } token_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[rtl/core/slcd_front.sv]
// Front end: frame hunt, SLIP unescape, overflow checks, token generation.
`default_nettype none
module slcd_front #(
    parameter int MAX_PACKET = slcd_pkg::MAX_PACKET_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               s_tvalid,
    output logic              s_tready,
    input  wire  [7:0]        s_tdata,   // [7:0] rx_byte
    output logic              tok_valid,
    input  wire               tok_ready,
    output slcd_pkg::token_t  tok
);

    localparam int ENC_W = $clog2(2 * MAX_PACKET + 1);
    localparam int CNT_W = $clog2(MAX_PACKET + 1);

    logic             in_frame_reg, in_frame_next;
    logic             esc_reg, esc_next;
    logic [ENC_W-1:0] enc_reg, enc_next;
    logic [CNT_W-1:0] dec_reg, dec_next;
    logic             dovf_reg, dovf_next;
    logic             take;
    logic             emit;

    assign s_tready = tok_ready;
    assign take     = s_tvalid & s_tready;
    assign tok_valid = take & emit;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        enc_next      = enc_reg;
        dec_next      = dec_reg;
        dovf_next     = dovf_reg;
        emit          = 1'b0;
        tok.kind      = slcd_pkg::TOK_DATA;
        tok.data      = s_tdata;
        tok.dovf      = dovf_reg;
        if (!in_frame_reg)
        begin
            if (s_tdata == slcd_pkg::BYTE_END)
            begin
                in_frame_next = 1'b1;
                esc_next      = 1'b0;
                enc_next      = ENC_W'(1);
                dec_next      = '0;
                dovf_next     = 1'b0;
            end
        end
        else if (s_tdata == slcd_pkg::BYTE_END)
        begin
            emit          = 1'b1;
            tok.kind      = slcd_pkg::TOK_CLOSE;
            in_frame_next = 1'b0;
        end
        else if (enc_reg >= ENC_W'(2 * MAX_PACKET))
        begin
            emit          = 1'b1;
            tok.kind      = slcd_pkg::TOK_ABORT;
            in_frame_next = 1'b0;
        end
        else
        begin
            enc_next = enc_reg + ENC_W'(1);
            if (dovf_reg)
            begin
                emit = 1'b0;
            end
            else if (s_tdata == slcd_pkg::BYTE_ESC)
            begin
                esc_next = 1'b1;
            end
            else if (esc_reg)
            begin
                esc_next = 1'b0;
                if (dec_reg >= CNT_W'(MAX_PACKET))
                    dovf_next = 1'b1;
                else if (s_tdata == slcd_pkg::BYTE_ESC_END)
                begin
                    emit     = 1'b1;
                    tok.data = slcd_pkg::BYTE_END;
                    dec_next = dec_reg + CNT_W'(1);
                end
                else if (s_tdata == slcd_pkg::BYTE_ESC_ESC)
                begin
                    emit     = 1'b1;
                    tok.data = slcd_pkg::BYTE_ESC;
                    dec_next = dec_reg + CNT_W'(1);
                end
            end
            else if (dec_reg >= CNT_W'(MAX_PACKET))
            begin
                dovf_next = 1'b1;
            end
            else
            begin
                emit     = 1'b1;
                dec_next = dec_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            enc_reg      <= '0;
            dec_reg      <= '0;
            dovf_reg     <= 1'b0;
        end
        else if (take)
        begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            enc_reg      <= enc_next;
            dec_reg      <= dec_next;
            dovf_reg     <= dovf_next;
        end
    end

endmodule
`default_nettype wire

[rtl/core/slcd_fifo.sv]
// Two-entry token queue between front and back ends.
`default_nettype none
module slcd_fifo (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push_valid,
    output logic              push_ready,
    input  slcd_pkg::token_t  push_tok,
    output logic              pop_valid,
    input  wire               pop_ready,
    output slcd_pkg::token_t  pop_tok
);

    slcd_pkg::token_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_tok    = mem[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

[rtl/core/slcd_back.sv]
// Back end: header parse, CRC-16-CCITT, payload and status word output.
`default_nettype none
module slcd_back #(
    parameter int MAX_PAYLOAD = slcd_pkg::MAX_PAYLOAD_DEF,
    parameter int MAX_PACKET  = slcd_pkg::MAX_PACKET_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  tok_valid,
    output logic                                 tok_ready,
    input  slcd_pkg::token_t                     tok,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [slcd_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                 m_tlast
);

    localparam int CNT_W = $clog2(MAX_PACKET + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [15:0]      len_reg, len_next;
    logic [15:0]      crc_reg, crc_next;
    logic [15:0]      crcc_reg, crcc_next;

    logic                              out_valid_reg, out_valid_next;
    logic                              out_last_reg, out_last_next;
    logic [slcd_pkg::OUT_DATA_W-1:0]   out_data_reg, out_data_next;

    logic             pop;
    logic [16:0]      idx17;
    logic [16:0]      len17;
    logic [16:0]      cnt17;
    logic [16:0]      len_cur17;
    slcd_pkg::status_t status;

    assign tok_ready = !out_valid_reg || m_tready;
    assign pop       = tok_valid & tok_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tlast   = out_last_reg;
    assign m_tdata   = out_data_reg;

    assign idx17     = 17'(cnt_reg);
    assign cnt17     = 17'(cnt_reg);
    assign len_cur17 = {1'b0, len_reg};

    // close status by priority
    always_comb
    begin
        if (tok.dovf || cnt17 < 17'(slcd_pkg::FRAME_EXTRA))
            status = slcd_pkg::ST_SHORT;
        else if (len_cur17 > 17'(MAX_PAYLOAD))
            status = slcd_pkg::ST_LEN;
        else if (cnt17 < len_cur17 + 17'(slcd_pkg::FRAME_EXTRA))
            status = slcd_pkg::ST_SHORT;
        else if (crc_reg != crcc_reg)
            status = slcd_pkg::ST_CRC;
        else
            status = slcd_pkg::ST_OK;
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        len_next       = len_reg;
        crc_next       = crc_reg;
        crcc_next      = crcc_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        out_last_next  = out_last_reg;
        out_data_next  = out_data_reg;
        len17          = len_cur17;
        if (pop)
        begin
            case (tok.kind)
                slcd_pkg::TOK_DATA:
                begin
                    if (cnt_reg == CNT_W'(0))
                        cmd_next = tok.data;
                    else if (cnt_reg == CNT_W'(1))
                        len_next = {8'h00, tok.data};
                    else if (cnt_reg == CNT_W'(2))
                        len_next = {tok.data, len_reg[7:0]};
                    len17 = {1'b0, len_next};
                    if (idx17 < 17'(slcd_pkg::HDR_BYTES)
                        || idx17 < len17 + 17'(slcd_pkg::HDR_BYTES))
                    begin
                        crc_next = slcd_pkg::crc_byte(crc_reg, tok.data);
                        if (idx17 >= 17'(slcd_pkg::HDR_BYTES) && len17 <= 17'(MAX_PAYLOAD))
                        begin
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b0;
                            out_data_next  = {{(slcd_pkg::OUT_DATA_W-8){1'b0}}, tok.data};
                        end
                    end
                    else if (idx17 == len17 + 17'(slcd_pkg::HDR_BYTES))
                        crcc_next = {crcc_reg[15:8], tok.data};
                    else if (idx17 == len17 + 17'(slcd_pkg::HDR_BYTES + 1))
                        crcc_next = {tok.data, crcc_reg[7:0]};
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                slcd_pkg::TOK_CLOSE, slcd_pkg::TOK_ABORT:
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    // {pad, crc, len, cmd, status, data}
                    out_data_next  = {5'd0, crcc_reg, len_reg, cmd_reg,
                                      (tok.kind == slcd_pkg::TOK_ABORT)
                                          ? slcd_pkg::ST_OVF : status,
                                      8'h00};
                    cnt_next  = '0;
                    cmd_next  = 8'h00;
                    len_next  = 16'h0000;
                    crc_next  = slcd_pkg::CRC_INIT;
                    crcc_next = 16'h0000;
                end
                default:
                begin
                    cnt_next = cnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            cmd_reg       <= 8'h00;
            len_reg       <= 16'h0000;
            crc_reg       <= slcd_pkg::CRC_INIT;
            crcc_reg      <= 16'h0000;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            cmd_reg       <= cmd_next;
            len_reg       <= len_next;
            crc_reg       <= crc_next;
            crcc_reg      <= crcc_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule
`default_nettype wire

[rtl/core/slip_crc_packet_deframer_core.sv]
// Top level of the SLIP deframer with CRC-16-CCITT check.
//
//  channel  | dir | payload
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | tdata[7:0] rx_byte
//  m_axis   | out | tlast is_frame_end; tdata data_byte, frame_status,
//           |     | command_code, payload_len, received_crc (low bit up)
//
// One byte per cycle while m_tready keeps the token queue from filling; each byte
// goes front classify -> two-entry token queue -> back CRC and output register.
// The back end does its header, CRC and compare work combinationally ahead of its output register.
// Reset (rst_n low, async) puts the block in hunt mode with an empty queue.
// m_tready low stalls only the back end; s_tready drops once the queue fills.
`default_nettype none
module slip_crc_packet_deframer_core #(
    parameter int MAX_PAYLOAD = slcd_pkg::MAX_PAYLOAD_DEF,
    parameter int MAX_PACKET  = slcd_pkg::MAX_PACKET_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [7:0]                       s_tdata,   // [7:0] rx_byte
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // [7:0] data_byte, [10:8] frame_status, [18:11] command_code,
    // [34:19] payload_len, [50:35] received_crc, [55:51] zero
    output logic [slcd_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                             m_tlast    // is_frame_end
);

    slcd_pkg::token_t f_tok;
    slcd_pkg::token_t b_tok;
    logic             f_valid, f_ready;
    logic             b_valid, b_ready;

    slcd_front #(
        .MAX_PACKET (MAX_PACKET)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .tok_valid (f_valid),
        .tok_ready (f_ready),
        .tok       (f_tok)
    );

    slcd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_tok   (f_tok),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_tok    (b_tok)
    );

    slcd_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .MAX_PACKET  (MAX_PACKET)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (b_valid),
        .tok_ready (b_ready),
        .tok       (b_tok),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the SLIP deframer with CRC-16-CCITT check.
`default_nettype none
module tb_top;
    import slcd_pkg::*;

    localparam int ITEM_TARGET   = 950;
    localparam int SHOW_MAX      = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct {
        logic [7:0]  value;
        int unsigned gap;
        bit          drain;
    } rx_item_t;

    typedef struct {
        bit          fin;
        logic [7:0]  dbyte;
        status_t     st;
        logic [7:0]  cmd;
        logic [15:0] plen;
        logic [15:0] rcrc;
    } deframe_word_t;

    typedef enum {
        SHAPE_GOOD,
        SHAPE_BAD_CRC,
        SHAPE_TRUNC,
        SHAPE_TRAIL,
        SHAPE_HUGE_LEN,
        SHAPE_LEN_SHORT,
        SHAPE_JUNK,
        SHAPE_EMPTY
    } frame_shape_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [7:0]            s_tdata  = 8'h00;
    logic                  m_tready = 1'b0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire  [OUT_DATA_W-1:0] m_tdata;
    wire                   m_tlast;

    slip_crc_packet_deframer_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    rx_item_t      rx_pending[$];
    deframe_word_t expected_words[$];
    logic [7:0]    frame_body[$];

    // deframer shadow state
    bit          hunt_open;
    bit          esc_held;
    int unsigned enc_bytes;
    int unsigned dec_bytes;
    bit          dec_overrun;
    logic [7:0]  cmd_seen;
    logic [15:0] len_seen;
    logic [15:0] crc_calc;
    logic [15:0] crc_sent;

    int unsigned calm_left;
    bit          drain_next;
    int unsigned gap_left    = 0;
    int unsigned settle_left = SETTLE_CYCLES;
    int unsigned stall_left  = 0;
    int unsigned ready_calm  = 0;
    int unsigned cycle_cnt   = 0;

    int fail_cnt     = 0;
    int bytes_taken  = 0;
    int data_words   = 0;
    int status_words = 0;
    int frames_built = 0;
    int drain_count  = 0;
    int status_seen[5];

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    task automatic push_status(input status_t s);
        deframe_word_t w;
        w.fin   = 1'b1;
        w.dbyte = 8'h00;
        w.st    = s;
        w.cmd   = cmd_seen;
        w.plen  = len_seen;
        w.rcrc  = crc_sent;
        expected_words.push_back(w);
    endtask

    // one decoded byte: header, payload (emitted), then the carried CRC
    task automatic absorb(input logic [7:0] v);
        int unsigned   idx;
        deframe_word_t w;
        idx = dec_bytes;
        if (idx == 0)
            cmd_seen = v;
        else if (idx == 1)
            len_seen = {8'h00, v};
        else if (idx == 2)
            len_seen[15:8] = v;
        if (idx < HDR_BYTES || idx - HDR_BYTES < len_seen)
        begin
            crc_calc = crc16_update(crc_calc, v);
            if (idx >= HDR_BYTES && len_seen <= MAX_PAYLOAD_DEF)
            begin
                w.fin   = 1'b0;
                w.dbyte = v;
                w.st    = ST_OK;
                w.cmd   = 8'h00;
                w.plen  = 16'h0000;
                w.rcrc  = 16'h0000;
                expected_words.push_back(w);
            end
        end
        else if (idx == len_seen + HDR_BYTES)
            crc_sent[7:0] = v;
        else if (idx == len_seen + HDR_BYTES + 1)
            crc_sent[15:8] = v;
        dec_bytes = idx + 1;
    endtask

    function automatic status_t close_verdict();
        if (dec_overrun || dec_bytes < FRAME_EXTRA)
            return ST_SHORT;
        if (len_seen > MAX_PAYLOAD_DEF)
            return ST_LEN;
        if (dec_bytes < len_seen + FRAME_EXTRA)
            return ST_SHORT;
        if (crc_calc != crc_sent)
            return ST_CRC;
        return ST_OK;
    endfunction

    task automatic predict_rx(input logic [7:0] b);
        if (!hunt_open)
        begin
            if (b == BYTE_END)
            begin
                hunt_open   = 1'b1;
                esc_held    = 1'b0;
                enc_bytes   = 1;
                dec_bytes   = 0;
                dec_overrun = 1'b0;
                cmd_seen    = 8'h00;
                len_seen    = 16'h0000;
                crc_calc    = CRC_INIT;
                crc_sent    = 16'h0000;
            end
            return;
        end
        if (b == BYTE_END)
        begin
            push_status(close_verdict());
            hunt_open = 1'b0;
            return;
        end
        if (enc_bytes >= 2 * MAX_PACKET_DEF)
        begin
            push_status(ST_OVF);
            hunt_open = 1'b0;
            return;
        end
        enc_bytes++;
        if (dec_overrun)
            return;
        if (b == BYTE_ESC)
            esc_held = 1'b1;
        else if (esc_held)
        begin
            esc_held = 1'b0;
            if (dec_bytes >= MAX_PACKET_DEF)
                dec_overrun = 1'b1;
            else if (b == BYTE_ESC_END)
                absorb(BYTE_END);
            else if (b == BYTE_ESC_ESC)
                absorb(BYTE_ESC);
        end
        else if (dec_bytes >= MAX_PACKET_DEF)
            dec_overrun = 1'b1;
        else
            absorb(b);
    endtask

    // mostly back-to-back, sometimes short gaps, rarely long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm_left != 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_payload_byte();
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 3))
                0: return BYTE_END;
                1: return BYTE_ESC;
                2: return BYTE_ESC_END;
                default: return BYTE_ESC_ESC;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_non_end();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == BYTE_END);
        return b;
    endfunction

    function automatic logic [7:0] pick_unknown();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b inside {BYTE_END, BYTE_ESC, BYTE_ESC_END, BYTE_ESC_ESC});
        return b;
    endfunction

    task automatic queue_raw(input logic [7:0] b);
        rx_item_t it;
        it.value   = b;
        it.gap     = pick_gap();
        it.drain   = drain_next;
        drain_next = 1'b0;
        rx_pending.push_back(it);
    endtask

    task automatic queue_decoded(input logic [7:0] v);
        if (v == BYTE_END)
        begin
            queue_raw(BYTE_ESC);
            queue_raw(BYTE_ESC_END);
        end
        else if (v == BYTE_ESC)
        begin
            queue_raw(BYTE_ESC);
            queue_raw(BYTE_ESC_ESC);
        end
        else
            queue_raw(v);
    endtask

    task automatic build_body(input logic [7:0] cmd, input logic [15:0] len_field,
                              input int n_pay);
        frame_body.delete();
        frame_body.push_back(cmd);
        frame_body.push_back(len_field[7:0]);
        frame_body.push_back(len_field[15:8]);
        repeat (n_pay) frame_body.push_back(rand_payload_byte());
    endtask

    // append the CRC, low byte first; a nonzero mask corrupts it
    task automatic seal_body(input logic [15:0] mask);
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_body[i]) c = crc16_update(c, frame_body[i]);
        c = c ^ mask;
        frame_body.push_back(c[7:0]);
        frame_body.push_back(c[15:8]);
    endtask

    // noise: unknown escapes (byte dropped) or a doubled ESC before a real escape
    task automatic send_body(input int noise_pct, input int cut, input int extra);
        queue_raw(BYTE_END);
        for (int i = 0; i < frame_body.size() - cut; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
            begin
                queue_raw(BYTE_ESC);
                if (frame_body[i] != BYTE_END && frame_body[i] != BYTE_ESC)
                    queue_raw(pick_unknown());
            end
            queue_decoded(frame_body[i]);
        end
        repeat (extra) queue_decoded(rand_payload_byte());
        queue_raw(BYTE_END);
    endtask

    function automatic frame_shape_t pick_shape();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return SHAPE_GOOD;
        if (r < 55) return SHAPE_BAD_CRC;
        if (r < 65) return SHAPE_TRUNC;
        if (r < 72) return SHAPE_TRAIL;
        if (r < 80) return SHAPE_HUGE_LEN;
        if (r < 88) return SHAPE_LEN_SHORT;
        if (r < 95) return SHAPE_JUNK;
        return SHAPE_EMPTY;
    endfunction

    task automatic add_random_frame();
        frame_shape_t shape;
        int           len;
        shape = pick_shape();
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        case (shape)
            SHAPE_GOOD:
            begin
                build_body(8'($urandom_range(0, 255)), 16'(len), len);
                seal_body(16'h0000);
                send_body(($urandom_range(0, 3) == 0) ? 15 : 0, 0, 0);
            end
            SHAPE_BAD_CRC:
            begin
                build_body(8'($urandom_range(0, 255)), 16'(len), len);
                seal_body(16'($urandom_range(1, 65535)));
                send_body(0, 0, 0);
            end
            SHAPE_TRUNC:
            begin
                build_body(8'($urandom_range(0, 255)), 16'(len), len);
                seal_body(16'h0000);
                send_body(0, $urandom_range(1, 3), 0);
            end
            SHAPE_TRAIL:
            begin
                build_body(8'($urandom_range(0, 255)), 16'(len), len);
                seal_body(16'h0000);
                send_body(0, 0, $urandom_range(1, 3));
            end
            SHAPE_HUGE_LEN:
            begin
                case ($urandom_range(0, 2))
                    0: len = MAX_PAYLOAD_DEF + 1;
                    1: len = 65535;
                    default: len = $urandom_range(MAX_PAYLOAD_DEF + 1, 65535);
                endcase
                build_body(8'($urandom_range(0, 255)), 16'(len), $urandom_range(0, 6));
                seal_body(16'($urandom_range(0, 65535)));
                send_body(0, 0, 0);
            end
            SHAPE_LEN_SHORT:
            begin
                len = $urandom_range(5, 20);
                build_body(8'($urandom_range(0, 255)), 16'(len), $urandom_range(0, len - 1));
                seal_body(16'h0000);
                send_body(0, 0, 0);
            end
            SHAPE_JUNK:
            begin
                queue_raw(BYTE_END);
                repeat ($urandom_range(0, 8)) queue_raw(pick_non_end());
                queue_raw(BYTE_END);
            end
            default:
            begin
                queue_raw(BYTE_END);
                queue_raw(BYTE_END);
            end
        endcase
    endtask

    task automatic build_stimulus();
        // bytes seen while hunting are dropped
        queue_raw(8'hFF);
        queue_raw(BYTE_ESC);
        // empty frame
        queue_raw(BYTE_END);
        queue_raw(BYTE_END);
        // smallest good frame
        build_body(8'hFF, 16'h0000, 0);
        seal_body(16'h0000);
        send_body(0, 0, 0);
        // escaped END/ESC payload, unknown escape and ESC ESC inside, bad CRC
        frame_body = {8'h00, 8'h02, 8'h00, BYTE_END, BYTE_ESC};
        seal_body(16'h0100);
        queue_raw(BYTE_END);
        foreach (frame_body[i])
        begin
            if (i == 4)
            begin
                queue_raw(BYTE_ESC);
                queue_raw(8'h41);
                queue_raw(BYTE_ESC);
            end
            queue_decoded(frame_body[i]);
        end
        queue_raw(BYTE_END);
        // largest length field; the frame closes right after an ESC
        queue_raw(BYTE_END);
        queue_raw(8'h7E);
        queue_raw(8'hFF);
        queue_raw(8'hFF);
        queue_raw(8'h11);
        queue_raw(8'h22);
        queue_raw(BYTE_ESC);
        queue_raw(BYTE_END);

        // long frames come early so that the total stays near the target
        while (rx_pending.size() < ITEM_TARGET || frames_built <= 18)
        begin
            if (frames_built == 3 || $urandom_range(0, 99) < 3)
                drain_next = 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 4)) queue_raw(pick_non_end());
            if (frames_built == 6)
            begin
                build_body(8'($urandom_range(0, 255)), 16'(MAX_PAYLOAD_DEF), MAX_PAYLOAD_DEF);
                seal_body(16'h0000);
                send_body(0, 0, 0);
            end
            else if (frames_built == 12)
            begin
                // decoded overrun on the last plain byte, then a normal close
                queue_raw(BYTE_END);
                repeat (MAX_PACKET_DEF + 1) queue_raw(8'h5A);
                queue_raw(BYTE_END);
            end
            else if (frames_built == 18)
            begin
                // one byte past the encoded limit, no closing END
                queue_raw(BYTE_END);
                repeat (2 * MAX_PACKET_DEF) queue_raw(pick_non_end());
            end
            else
                add_random_frame();
            frames_built++;
        end
    endtask

    // sender
    always @(posedge clk)
    begin : drive_blk
        rx_item_t head;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (rx_pending.size() == 0)
                s_tvalid <= 1'b0;
            else if (rx_pending[0].drain && (expected_words.size() != 0 || settle_left != 0))
            begin
                if (expected_words.size() == 0)
                    settle_left--;
                s_tvalid <= 1'b0;
            end
            else
            begin
                head = rx_pending.pop_front();
                if (head.drain)
                    drain_count++;
                s_tvalid    <= 1'b1;
                s_tdata     <= head.value;
                gap_left    = (rx_pending.size() != 0) ? rx_pending[0].gap : 0;
                settle_left = SETTLE_CYCLES;
            end
        end
    end

    // receiver: predicts on accepted bytes, checks accepted words
    always @(posedge clk)
    begin : watch_blk
        deframe_word_t want;
        bit            bad;
        int unsigned   r;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_rx(s_tdata);
                bytes_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= SHOW_MAX)
                        $display("unexpected word: last=%0b tdata=%h", m_tlast, m_tdata);
                end
                else
                begin
                    want = expected_words.pop_front();
                    bad  = (m_tlast !== want.fin) || (m_tdata[7:0] !== want.dbyte)
                        || (m_tdata[10:8] !== want.st) || (m_tdata[18:11] !== want.cmd)
                        || (m_tdata[34:19] !== want.plen) || (m_tdata[50:35] !== want.rcrc)
                        || (m_tdata[55:51] !== 5'd0);
                    if (bad)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= SHOW_MAX)
                        begin
                            $display("mismatch exp: last=%0b data=%h st=%0d cmd=%h len=%h crc=%h",
                                     want.fin, want.dbyte, want.st, want.cmd, want.plen,
                                     want.rcrc);
                            $display("         got: last=%0b data=%h st=%0d cmd=%h len=%h crc=%h"
                                     , m_tlast, m_tdata[7:0], m_tdata[10:8], m_tdata[18:11],
                                     m_tdata[34:19], m_tdata[50:35]);
                        end
                    end
                    if (want.fin)
                    begin
                        status_words++;
                        status_seen[want.st]++;
                    end
                    else
                        data_words++;
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (ready_calm != 0)
                    ready_calm--;
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 2)
                        ready_calm = $urandom_range(30, 120);
                    else if (r < 70)
                        stall_left = 0;
                    else if (r < 95)
                        stall_left = $urandom_range(1, 3);
                    else
                        stall_left = $urandom_range(8, 40);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected", cycle_cnt,
                     expected_words.size());
            $display("** slip_crc_packet_deframer_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        foreach (status_seen[i]) status_seen[i] = 0;
        build_stimulus();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        while (rx_pending.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d bytes over %0d random frames plus directed ones, %0d full drains.",
                 bytes_taken, frames_built, drain_count);
        $display("Checked %0d payload words, %0d frame ends (ok %0d short %0d len %0d crc %0d ovf %0d).",
                 data_words, status_words, status_seen[ST_OK], status_seen[ST_SHORT],
                 status_seen[ST_LEN], status_seen[ST_CRC], status_seen[ST_OVF]);
        if (fail_cnt == 0)
            $display("** slip_crc_packet_deframer_core: PASSED **");
        else
            $display("** slip_crc_packet_deframer_core: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
rtl/core/slcd_pkg.sv
rtl/core/slcd_front.sv
rtl/core/slcd_fifo.sv
rtl/core/slcd_back.sv
rtl/core/slip_crc_packet_deframer_core.sv
sim/tb_top.sv
